// File: src/bpa_pkg.sv
package bpa_pkg;

    localparam int LEAVES     = 1024;
    localparam int LOG_LEAVES = $clog2(LEAVES);
    localparam int TREE_NODES = 2 * LEAVES;
    localparam int ADDR_W     = LOG_LEAVES + 1;
    localparam int OFF_W      = 10;
    localparam int CNT_W      = 11;
    localparam int VAL_W      = CNT_W;
    localparam int SIZE_W     = CNT_W + 1;
    localparam int SHIFT_W    = $clog2(SIZE_W);
    localparam int DEPTH_W    = $clog2(LOG_LEAVES + 1);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_INVALID  = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DESCEND,
        ST_WRITE,
        ST_CLIMB
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [CNT_W-1:0]   page_count;
        logic [OFF_W-1:0]   block_offset;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   alloc_offset;
        logic [CNT_W-1:0]   pages_left;
    } result_t;

    // log2 of the request size rounded up to a power of two, zero taken as one
    function automatic logic [SHIFT_W-1:0] size_log2(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0]   m;
        logic [SHIFT_W-1:0] k;
        m = (cnt == '0) ? '0 : cnt - 1'b1;
        k = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (m[i])
            begin
                k = SHIFT_W'(i + 1);
            end
        end
        return k;
    endfunction

    // span of a tree node from its index, zero for the unused node
    function automatic logic [VAL_W-1:0] node_span(input logic [ADDR_W-1:0] a);
        logic [VAL_W-1:0] v;
        v = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            if (a[i])
            begin
                v = VAL_W'(LEAVES >> i);
            end
        end
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] depth_span(input logic [DEPTH_W-1:0] d);
        return VAL_W'(LEAVES >> d);
    endfunction

endpackage

// File: src/bpa_ram.sv
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/buddy_page_allocator_core.sv
// Binary buddy allocator over 1024 pages. A request is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with done high, and it must be taken
// then since the core cannot be stalled. The largest-free tree lives in one 2048-entry RAM
// with one read and one write port. An allocate descends from the root to the block's depth
// d (10 minus log2 of its size) and then climbs back; a free starts at depth d and climbs.
// The descent reads one node per cycle and the climb writes one ancestor per cycle while
// reading the next sibling. A rejected request is answered from the check state. After
// reset the core stays busy while it fills all 2048 tree nodes with their initial spans.
module buddy_page_allocator_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpa_pkg::request_t request,
    output logic              done,
    output bpa_pkg::result_t  result
);

    bpa_pkg::state_t                 state_reg, state_next;
    bpa_pkg::op_t                    op_reg, op_next;
    logic [bpa_pkg::SHIFT_W-1:0]     k_reg, k_next;
    logic [bpa_pkg::OFF_W-1:0]       off_reg, off_next;
    logic [bpa_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    logic [bpa_pkg::DEPTH_W-1:0]     depth_reg, depth_next;
    logic [bpa_pkg::DEPTH_W-1:0]     target_reg, target_next;
    logic [bpa_pkg::VAL_W-1:0]       cur_reg, cur_next;
    logic [bpa_pkg::CNT_W-1:0]       free_reg, free_next;
    logic [bpa_pkg::VAL_W-1:0]       root_reg, root_next;
    logic [bpa_pkg::ADDR_W-1:0]      clr_reg, clr_next;
    logic                            done_reg, done_next;
    bpa_pkg::result_t                result_reg, result_next;

    logic                            we;
    logic [bpa_pkg::ADDR_W-1:0]      waddr;
    logic [bpa_pkg::VAL_W-1:0]       wdata;
    logic [bpa_pkg::ADDR_W-1:0]      raddr;
    logic [bpa_pkg::VAL_W-1:0]       rdata;

    logic [bpa_pkg::SIZE_W-1:0]      size;
    logic [bpa_pkg::SIZE_W-1:0]      free_ext;
    logic [bpa_pkg::SIZE_W-1:0]      free_sum;
    logic                            alloc_bad;
    logic                            free_bad;
    logic                            check_fail;
    logic [bpa_pkg::DEPTH_W-1:0]     target;
    logic [bpa_pkg::ADDR_W-1:0]      free_node;
    logic                            go_right;
    logic [bpa_pkg::ADDR_W-1:0]      next_idx;
    logic [bpa_pkg::DEPTH_W-1:0]     next_depth;
    logic [bpa_pkg::VAL_W-1:0]       parent_span;
    logic [bpa_pkg::VAL_W:0]         pair_sum;
    logic [bpa_pkg::VAL_W-1:0]       pair_max;
    logic [bpa_pkg::VAL_W-1:0]       merged;
    logic [bpa_pkg::ADDR_W+bpa_pkg::OFF_W-1:0] node_base;
    logic                            at_root;

    bpa_ram #(
        .WIDTH (bpa_pkg::VAL_W),
        .DEPTH (bpa_pkg::TREE_NODES)
    ) u_tree (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // request checks
    assign size      = bpa_pkg::SIZE_W'(1) << k_reg;
    assign free_ext  = {1'b0, free_reg};
    assign free_sum  = free_ext + size;
    assign alloc_bad = (size > free_ext) || ({1'b0, root_reg} < size);
    assign free_bad  = (k_reg > bpa_pkg::SHIFT_W'(bpa_pkg::LOG_LEAVES))
                    || (32'(off_reg) >= bpa_pkg::LEAVES)
                    || ((off_reg & bpa_pkg::OFF_W'(size - 1'b1)) != '0)
                    || (free_sum > bpa_pkg::SIZE_W'(bpa_pkg::LEAVES));
    assign check_fail = (op_reg == bpa_pkg::OP_ALLOC) ? alloc_bad : free_bad;
    assign target     = bpa_pkg::DEPTH_W'(bpa_pkg::LOG_LEAVES) - bpa_pkg::DEPTH_W'(k_reg);
    assign free_node  = (bpa_pkg::ADDR_W'(bpa_pkg::LEAVES) + bpa_pkg::ADDR_W'(off_reg))
                        >> k_reg;

    // descent, left child first
    assign go_right   = ({1'b0, rdata} < size);
    assign next_idx   = bpa_pkg::ADDR_W'({idx_reg, go_right});
    assign next_depth = depth_reg + 1'b1;

    // ancestor refresh, buddies merge on free
    assign parent_span = bpa_pkg::depth_span(depth_reg);
    assign pair_sum    = {1'b0, cur_reg} + {1'b0, rdata};
    assign pair_max    = (cur_reg > rdata) ? cur_reg : rdata;
    assign merged      = ((op_reg == bpa_pkg::OP_FREE) && (pair_sum == {1'b0, parent_span}))
                         ? parent_span : pair_max;

    assign node_base = {{bpa_pkg::OFF_W{1'b0}}, idx_reg} << k_reg;
    assign at_root   = (idx_reg == bpa_pkg::ADDR_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                if (clr_reg == bpa_pkg::ADDR_W'(bpa_pkg::TREE_NODES - 1))
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = bpa_pkg::ST_CHECK;
                end
            end
            bpa_pkg::ST_CHECK:
            begin
                if (check_fail)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
                else if ((op_reg == bpa_pkg::OP_ALLOC) && (target != '0))
                begin
                    state_next = bpa_pkg::ST_DESCEND;
                end
                else
                begin
                    state_next = bpa_pkg::ST_WRITE;
                end
            end
            bpa_pkg::ST_DESCEND:
            begin
                if (next_depth == target_reg)
                begin
                    state_next = bpa_pkg::ST_WRITE;
                end
            end
            bpa_pkg::ST_WRITE:
            begin
                if (at_root)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bpa_pkg::ST_CLIMB;
                end
            end
            bpa_pkg::ST_CLIMB:
            begin
                if (at_root)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bpa_pkg::ST_CLIMB;
                end
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        k_next      = k_reg;
        off_next    = off_reg;
        idx_next    = idx_reg;
        depth_next  = depth_reg;
        target_next = target_reg;
        cur_next    = cur_reg;
        free_next   = free_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = cur_reg;
        raddr       = idx_reg ^ bpa_pkg::ADDR_W'(1);
        unique case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = bpa_pkg::node_span(clr_reg);
                clr_next = clr_reg + 1'b1;
            end
            bpa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = request.operation;
                    k_next   = bpa_pkg::size_log2(request.page_count);
                    off_next = request.block_offset;
                end
            end
            bpa_pkg::ST_CHECK:
            begin
                target_next = target;
                if (check_fail)
                begin
                    done_next                = 1'b1;
                    result_next.status       = (op_reg == bpa_pkg::OP_ALLOC)
                                               ? bpa_pkg::STATUS_NO_SPACE
                                               : bpa_pkg::STATUS_INVALID;
                    result_next.alloc_offset = '0;
                    result_next.pages_left   = free_reg;
                end
                else if (op_reg == bpa_pkg::OP_ALLOC)
                begin
                    free_next  = free_reg - bpa_pkg::CNT_W'(size);
                    idx_next   = bpa_pkg::ADDR_W'(1);
                    depth_next = '0;
                    cur_next   = '0;
                    raddr      = bpa_pkg::ADDR_W'(2);
                end
                else
                begin
                    free_next  = bpa_pkg::CNT_W'(free_sum);
                    idx_next   = free_node;
                    depth_next = target;
                    cur_next   = bpa_pkg::VAL_W'(size);
                end
            end
            bpa_pkg::ST_DESCEND:
            begin
                idx_next   = next_idx;
                depth_next = next_depth;
                raddr      = bpa_pkg::ADDR_W'({next_idx, 1'b0});
            end
            bpa_pkg::ST_WRITE:
            begin
                we         = 1'b1;
                idx_next   = idx_reg >> 1;
                depth_next = depth_reg - 1'b1;
                off_next   = (op_reg == bpa_pkg::OP_ALLOC) ? node_base[bpa_pkg::OFF_W-1:0]
                                                           : '0;
                if (at_root)
                begin
                    done_next                = 1'b1;
                    result_next.status       = bpa_pkg::STATUS_OK;
                    result_next.alloc_offset = (op_reg == bpa_pkg::OP_ALLOC)
                                               ? node_base[bpa_pkg::OFF_W-1:0] : '0;
                    result_next.pages_left   = free_reg;
                end
            end
            bpa_pkg::ST_CLIMB:
            begin
                we         = 1'b1;
                wdata      = merged;
                cur_next   = merged;
                idx_next   = idx_reg >> 1;
                depth_next = depth_reg - 1'b1;
                if (at_root)
                begin
                    done_next                = 1'b1;
                    result_next.status       = bpa_pkg::STATUS_OK;
                    result_next.alloc_offset = off_reg;
                    result_next.pages_left   = free_reg;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // root kept beside the RAM for the allocate check
    assign root_next = (we && (waddr == bpa_pkg::ADDR_W'(1))) ? wdata : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::ST_CLEAR;
            clr_reg   <= '0;
            free_reg  <= bpa_pkg::CNT_W'(bpa_pkg::LEAVES);
            root_reg  <= bpa_pkg::VAL_W'(bpa_pkg::LEAVES);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            root_reg  <= root_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        k_reg      <= k_next;
        off_reg    <= off_next;
        idx_reg    <= idx_next;
        depth_reg  <= depth_next;
        target_reg <= target_next;
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != bpa_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
